### hw/rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned TagW         = 32;
  localparam int unsigned PrioW        = 8;
  localparam int unsigned FillW        = 5;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned InDataW      = 40;
  localparam int unsigned OutDataW     = 48;

  localparam logic ActInsert = 1'b0;
  localparam logic ActRemove = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [TagW-1:0]  tag;
  } spq_entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_op_t;

endpackage
`default_nettype wire

### hw/rtl/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, shifts towards the tail on an
// insert ahead of it and towards the head on a remove.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire spq_op_t    op_i,
  input  wire logic       occupied_i,
  input  wire spq_entry_t new_entry_i,
  input  wire logic       left_lower_i,
  input  wire spq_entry_t left_entry_i,
  input  wire spq_entry_t right_entry_i,
  output logic            lower_o,
  output spq_entry_t      entry_o
);

  spq_entry_t entry_q, entry_d;

  assign lower_o = !occupied_i || (entry_q.prio < new_entry_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins) begin
      if (left_lower_i) begin
        entry_d = left_entry_i;
      end else if (lower_o) begin
        entry_d = new_entry_i;
      end
    end else if (op_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_insert_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded priority queue kept sorted in a row of cells; ties leave in order.
// ----------------------------------------------------------------------------
// Each accepted item's result is registered in the output register.
// Throughput: 1 item per cycle while s_axis_tready is high; every cell updates in the same cycle.
// s_axis_tready stays high while the output register is empty or being taken.
// Reset clears the entry count and the output valid; slot contents are
// undefined until written.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // tag[31:0], priority_req[39:32]
  input  wire logic                s_axis_tuser,   // action[0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // served_tag[31:0],
                                                   // served_priority[39:32],
                                                   // fill_level[44:40], zero
  output logic [StatusW-1:0]       m_axis_tuser    // status[1:0]
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  logic [StatusW-1:0]  out_status_q, out_status_d;
  spq_entry_t          out_entry_q, out_entry_d;
  logic [FillW-1:0]    out_fill_q;

  logic       accept, full, empty;
  spq_op_t    op;
  spq_entry_t new_entry;

  spq_entry_t cell_entry [DEPTH];
  logic       cell_lower [DEPTH];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(DEPTH));
  assign empty         = (count_q == '0);
  assign new_entry.tag  = s_axis_tdata[TagW-1:0];
  assign new_entry.prio = s_axis_tdata[TagW+PrioW-1:TagW];
  assign op.ins = accept && (s_axis_tuser == ActInsert) && !full;
  assign op.rem = accept && (s_axis_tuser == ActRemove) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       occupied;
    logic       left_lower;
    spq_entry_t left_entry;
    spq_entry_t right_entry;

    assign occupied = (CntW'(i) < count_q);
    if (i == 0) begin : g_head
      assign left_lower = 1'b0;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_lower = cell_lower[i-1];
      assign left_entry = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .occupied_i    (occupied),
      .new_entry_i   (new_entry),
      .left_lower_i  (left_lower),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .lower_o       (cell_lower[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    out_status_d = ST_DONE;
    out_entry_d  = '0;
    if (s_axis_tuser == ActInsert) begin
      if (full) begin
        out_status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        out_status_d = ST_EMPTY;
      end else begin
        count_d     = count_q - 1'b1;
        out_entry_d = cell_entry[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= out_status_d;
      out_entry_q  <= out_entry_d;
      out_fill_q   <= FillW'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(OutDataW - TagW - PrioW - FillW){1'b0}},
                          out_fill_q, out_entry_q.prio, out_entry_q.tag};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.ins |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not advance count");

  a_remove_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.rem |=> (out_entry_q == $past(cell_entry[0])))
    else $error("remove did not hand out head entry");

endmodule
`default_nettype wire

### dv/sorted_insert_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_tb
// Stream-level check of the sorted priority queue against a scoreboard model.
// A queued driver sends insert and remove requests, and a clocked monitor
// compares every result with the prediction made when its request was taken.
// Directed requests cover empty, full, ties and field extremes. Random bursts
// then swing the fill level between empty and full, under three idling mixes.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_tb;
  import spq_pkg::*;

  localparam int Depth      = DepthDefault;
  localparam int CycleLimit = 300000;
  localparam int PrintLimit = 50;

  typedef struct {
    logic             act;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
    int               phase;
  } request_t;

  typedef struct {
    spq_status_e      status;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
    logic [FillW-1:0] fill;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  request_t         pending_reqs[$];
  outcome_t         awaited_outcomes[$];
  request_t         on_bus;
  int               cur_phase = 0;
  int               tx_idle_pct[3] = '{6, 82, 0};
  int               rx_idle_pct[3] = '{82, 6, 0};

  logic [PrioW-1:0] held_prio[Depth];
  logic [TagW-1:0]  held_tag[Depth];
  int               held_count = 0;

  int               mismatches = 0;
  int               cycles = 0;
  int               n_insert = 0;
  int               n_remove = 0;
  int               n_full = 0;
  int               n_empty = 0;
  int               peak_fill = 0;

  sorted_insert_priority_queue #(
    .DEPTH(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // tag[31:0], priority_req[39:32]
    .s_axis_tuser (s_axis_tuser),   // action[0]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // served_tag[31:0], served_priority[39:32],
                                    // fill_level[44:40], zero
    .m_axis_tuser (m_axis_tuser)    // status[1:0]
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintLimit) $display("[%0t] %s", $time, msg);
  endtask

  function automatic outcome_t serve_request(input request_t req);
    outcome_t res;
    int       pos;
    bit       found;
    res.status = ST_DONE;
    res.tag    = '0;
    res.prio   = '0;
    if (req.act == ActInsert) begin
      n_insert++;
      if (held_count >= Depth) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        pos   = held_count;
        found = 1'b0;
        for (int i = 0; i < held_count; i++) begin
          if (!found && held_prio[i] < req.prio) begin
            pos   = i;
            found = 1'b1;
          end
        end
        for (int i = held_count; i > pos; i--) begin
          held_prio[i] = held_prio[i-1];
          held_tag[i]  = held_tag[i-1];
        end
        held_prio[pos] = req.prio;
        held_tag[pos]  = req.tag;
        held_count++;
        if (held_count > peak_fill) peak_fill = held_count;
      end
    end else begin
      n_remove++;
      if (held_count == 0) begin
        res.status = ST_EMPTY;
        n_empty++;
      end else begin
        res.tag  = held_tag[0];
        res.prio = held_prio[0];
        for (int i = 1; i < held_count; i++) begin
          held_prio[i-1] = held_prio[i];
          held_tag[i-1]  = held_tag[i];
        end
        held_count--;
      end
    end
    res.fill = held_count[FillW-1:0];
    return res;
  endfunction

  task automatic push_request(input logic act, input logic [TagW-1:0] tag,
                              input logic [PrioW-1:0] prio, input int phase);
    request_t req;
    req.act   = act;
    req.tag   = tag;
    req.prio  = prio;
    req.phase = phase;
    pending_reqs.push_back(req);
  endtask

  // driver: predict on acceptance, then present the next item or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) awaited_outcomes.push_back(serve_request(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 &&
            $urandom_range(0, 99) >= tx_idle_pct[pending_reqs[0].phase]) begin
          on_bus = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {on_bus.prio, on_bus.tag};
          s_axis_tuser  <= on_bus.act;
          cur_phase     <= on_bus.phase;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken result with the oldest prediction
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting: tuser=%0d tdata=%h",
                                    m_axis_tuser, m_axis_tdata));
        end else begin
          want = awaited_outcomes.pop_front();
          if (m_axis_tuser !== want.status || m_axis_tdata[31:0] !== want.tag ||
              m_axis_tdata[39:32] !== want.prio || m_axis_tdata[44:40] !== want.fill ||
              m_axis_tdata[47:45] !== 3'b000)
            report_mismatch($sformatf(
              "got status=%0d tag=%h prio=%0d fill=%0d pad=%b, want %0d %h %0d %0d",
              m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32],
              m_axis_tdata[44:40], m_axis_tdata[47:45],
              want.status, want.tag, want.prio, want.fill));
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct[cur_phase]);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("sorted_insert_priority_queue: mismatch");
      $finish;
    end
  end

  initial begin
    int   burst_len;
    int   mode;
    int   ins_pct;
    int   budget;
    logic act;
    logic [PrioW-1:0] prio;

    // empty remove, then fill to the brim with ties and extremes, then overflow
    push_request(ActRemove, 32'hffff_ffff, 8'hff, 0);
    push_request(ActInsert, 32'h0000_0000, 8'd0, 0);
    push_request(ActInsert, 32'hffff_ffff, 8'd255, 0);
    push_request(ActInsert, 32'h0000_0001, 8'd128, 0);
    push_request(ActInsert, 32'h0000_0002, 8'd128, 0);
    push_request(ActInsert, 32'h0000_0003, 8'd128, 0);
    push_request(ActInsert, 32'h0000_0004, 8'd255, 0);
    push_request(ActInsert, 32'h0000_0005, 8'd0, 0);
    push_request(ActInsert, 32'h0000_0006, 8'd1, 0);
    push_request(ActInsert, 32'h0000_0007, 8'd254, 0);
    push_request(ActInsert, 32'h0000_0008, 8'd127, 0);
    push_request(ActInsert, 32'h0000_0009, 8'd129, 0);
    push_request(ActInsert, 32'h0000_000a, 8'd64, 0);
    push_request(ActInsert, 32'h0000_000b, 8'd64, 0);
    push_request(ActInsert, 32'h0000_000c, 8'd200, 0);
    push_request(ActInsert, 32'h0000_000d, 8'd10, 0);
    push_request(ActInsert, 32'h0000_000e, 8'd255, 0);
    push_request(ActInsert, 32'h0000_000f, 8'd100, 0);
    push_request(ActInsert, 32'h0000_0010, 8'd255, 0);
    for (int i = 0; i < 6; i++) push_request(ActRemove, $urandom, PrioW'($urandom), 0);

    // bursts that lean towards filling, draining or neither
    for (int phase = 0; phase < 3; phase++) begin
      budget = 267;
      while (budget > 0) begin
        burst_len = $urandom_range(4, 24);
        mode      = $urandom_range(0, 2);
        ins_pct   = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
        for (int k = 0; k < burst_len && budget > 0; k++) begin
          act  = ($urandom_range(0, 99) < ins_pct) ? ActInsert : ActRemove;
          prio = $urandom_range(0, 1) ? PrioW'($urandom_range(0, 3)) : PrioW'($urandom);
          push_request(act, $urandom, prio, phase);
          budget--;
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || s_axis_tvalid || awaited_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (awaited_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_outcomes.size()));

    $display("covered %0d requests: %0d inserts (%0d refused full),",
             n_insert + n_remove, n_insert, n_full);
    $display("%0d removes (%0d refused empty), peak fill %0d of %0d, %0d bad, %0d cycles",
             n_remove, n_empty, peak_fill, Depth, mismatches, cycles);
    if (mismatches == 0) begin
      $display("sorted_insert_priority_queue: match");
    end else begin
      $display("sorted_insert_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
